// ===== hdl/i2cbm_pkg.sv =====
// package for the tick-driven i2c bit-level master
// holds the command codes, phase limits and the transfer payload structs
// no dependencies
`default_nettype none

package i2cbm_pkg;

    // command codes on the func field, also the running operation
    typedef enum logic [2:0] {
        OP_IDLE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4,
        OP_ADDR  = 3'd5
    } op_t;

    localparam int PHASE_W = 6;

    localparam logic [PHASE_W-1:0] LAST_START  = 6'd4;
    localparam logic [PHASE_W-1:0] LAST_STOP   = 6'd3;
    localparam logic [PHASE_W-1:0] WR_ACK_STEP = 6'd32;
    localparam logic [PHASE_W-1:0] RD_LAST_BIT = 6'd24;
    localparam logic [PHASE_W-1:0] RD_ACK_STEP = 6'd25;
    localparam logic [PHASE_W-1:0] RD_CLK_LOW  = 6'd26;

    localparam logic [7:0] MSB_MASK  = 8'h80;
    localparam logic [7:0] ADDR_MASK = 8'hfe;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] tx_byte;
        logic       read_not_write;
        logic       ack_ctrl;
        logic       sda_in;
    } cmd_t;

    typedef struct packed {
        logic       scl_low;
        logic       sda_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_ok;
    } res_t;

    // residue mod 3 of a 5-bit value, from bit weights 1,2,1,2,1
    function automatic logic [1:0] mod3_5b(input logic [4:0] x);
        logic [2:0] s;
        s = 3'(x[0]) + 3'(x[2]) + 3'(x[4]) + {1'b0, x[1], 1'b0} + {1'b0, x[3], 1'b0};
        if (s >= 3'd6)
            return 2'(s - 3'd6);
        else if (s >= 3'd3)
            return 2'(s - 3'd3);
        else
            return s[1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/i2c_bit_level_master.sv =====
// Tick-driven open-drain i2c master. Every accepted cmd transfer is one timing
// tick and produces exactly one result, presented on res the next cycle, or later
// while results ahead of it still wait for res_stall to drop; a new tick can be
// taken every cycle unless stalled. The tick's pin action, phase step and shift
// are done in one pass from the state registers into the result register. A
// two-entry output (result register plus skid register) lets cmd_stall stay
// low while one result waits; it rises only once the skid register is also full.
// depends on i2cbm_pkg
`default_nettype none

module i2c_bit_level_master (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cmd_valid,
    output logic                 cmd_stall,
    input  wire i2cbm_pkg::cmd_t cmd,
    output logic                 res_valid,
    input  wire logic            res_stall,
    output i2cbm_pkg::res_t      res
);
    import i2cbm_pkg::*;

    op_t               op_reg, op_next, cur_op;
    logic [PHASE_W-1:0] phase_reg, phase_next, cur_phase;
    logic [7:0]        shift_reg, shift_next, cur_shift;
    logic              scl_reg, scl_next;
    logic              sda_reg, sda_next;
    logic              ack_reg, ack_next;
    logic              want_reg, want_next;
    logic [7:0]        rx_reg, rx_next;
    logic              done;
    logic [1:0]        rd_slot;

    logic              out_valid_reg, skid_valid_reg;
    res_t              out_reg, skid_reg;
    res_t              res_new;
    logic              accept, taken;

    assign accept    = cmd_valid && !cmd_stall;
    assign taken     = out_valid_reg && !res_stall;
    assign cmd_stall = skid_valid_reg;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // command launch when idle
    always_comb
    begin
        cur_op    = op_reg;
        cur_phase = phase_reg;
        cur_shift = shift_reg;
        want_next = want_reg;
        if (op_reg == OP_IDLE) begin
            case (cmd.func) inside
                OP_START, OP_STOP, OP_WRITE, OP_READ:
                begin
                    cur_op    = op_t'(cmd.func);
                    cur_phase = '0;
                    cur_shift = cmd.tx_byte;
                    want_next = cmd.ack_ctrl;
                end
                OP_ADDR:
                begin
                    cur_op    = OP_WRITE;
                    cur_phase = '0;
                    cur_shift = ((cmd.tx_byte << 1) & ADDR_MASK) | {7'd0, cmd.read_not_write};
                    want_next = cmd.ack_ctrl;
                end
                default:
                begin
                    cur_op = OP_IDLE;
                end
            endcase
        end
    end

    assign rd_slot = mod3_5b(5'(cur_phase - 6'd1));

    // pin actions of the current phase
    always_comb
    begin
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        shift_next = cur_shift;
        ack_next   = ack_reg;
        rx_next    = rx_reg;
        done       = 1'b0;
        unique case (cur_op)
            OP_START:
            begin
                case (cur_phase)
                    6'd0:    scl_next = 1'b1;
                    6'd1:    sda_next = 1'b0;
                    6'd2:    scl_next = 1'b0;
                    6'd3:    sda_next = 1'b1;
                    default: scl_next = 1'b1;
                endcase
                done = cur_phase >= LAST_START;
            end
            OP_STOP:
            begin
                case (cur_phase)
                    6'd0:    scl_next = 1'b1;
                    6'd1:    sda_next = 1'b1;
                    6'd2:    scl_next = 1'b0;
                    default: sda_next = 1'b0;
                endcase
                done = cur_phase >= LAST_STOP;
            end
            OP_WRITE:
            begin
                if (cur_phase < WR_ACK_STEP) begin
                    case (cur_phase[1:0])
                        2'd0:    sda_next = (cur_shift & MSB_MASK) == 8'd0;
                        2'd1:    scl_next = 1'b0;
                        2'd2:    scl_next = 1'b1;
                        default:
                        begin
                            sda_next   = 1'b0;
                            shift_next = cur_shift << 1;
                        end
                    endcase
                end else if (cur_phase == WR_ACK_STEP) begin
                    ack_next = !cmd.sda_in;
                    scl_next = 1'b0;
                end else begin
                    scl_next = 1'b1;
                    done     = 1'b1;
                end
            end
            OP_READ:
            begin
                if (cur_phase == 6'd0) begin
                    sda_next   = 1'b0;
                    shift_next = 8'd0;
                end else if (cur_phase <= RD_LAST_BIT) begin
                    case (rd_slot)
                        2'd0:    scl_next = 1'b0;
                        2'd1:    shift_next = {cur_shift[6:0], cmd.sda_in};
                        default:
                        begin
                            scl_next = 1'b1;
                            if (cur_phase == RD_LAST_BIT)
                                rx_next = cur_shift;
                        end
                    endcase
                end else if (cur_phase == RD_ACK_STEP) begin
                    if (want_next)
                        sda_next = 1'b1;
                end else if (cur_phase == RD_CLK_LOW) begin
                    scl_next = 1'b0;
                end else begin
                    scl_next = 1'b1;
                    done     = 1'b1;
                end
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    // next operation and phase
    always_comb
    begin
        op_next    = cur_op;
        phase_next = cur_phase;
        if (cur_op != OP_IDLE) begin
            if (done) begin
                op_next    = OP_IDLE;
                phase_next = '0;
            end else begin
                phase_next = cur_phase + 6'd1;
            end
        end
    end

    always_comb
    begin
        res_new.scl_low  = scl_next;
        res_new.sda_low  = sda_next;
        res_new.busy_res = op_next != OP_IDLE;
        res_new.done_res = done;
        res_new.rx_byte  = rx_next;
        res_new.ack_ok   = ack_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            op_reg    <= OP_IDLE;
            phase_reg <= '0;
            shift_reg <= '0;
            scl_reg   <= 1'b0;
            sda_reg   <= 1'b0;
            ack_reg   <= 1'b0;
            want_reg  <= 1'b0;
            rx_reg    <= '0;
        end else if (accept) begin
            op_reg    <= op_next;
            phase_reg <= phase_next;
            shift_reg <= shift_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            ack_reg   <= ack_next;
            want_reg  <= want_next;
            rx_reg    <= rx_next;
        end
    end

    // result register with a skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                if (!out_valid_reg || taken)
                    out_valid_reg <= 1'b1;
                else
                    skid_valid_reg <= 1'b1;
            end else if (taken) begin
                out_valid_reg  <= skid_valid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            if (!out_valid_reg || taken)
                out_reg <= res_new;
            else
                skid_reg <= res_new;
        end else if (taken && skid_valid_reg) begin
            out_reg <= skid_reg;
        end
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while result register empty");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.done_res && out_reg.busy_res))
        else $error("result shows done and busy together");

    a_idle_phase_zero: assert property (@(posedge clk) disable iff (!rst_n)
        op_reg == OP_IDLE |-> phase_reg == '0)
        else $error("phase left nonzero while idle");

    a_start_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
        op_reg == OP_START |-> phase_reg <= LAST_START)
        else $error("start sequence ran past its last phase");

    a_state_holds_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |=> $stable(op_reg) && $stable(phase_reg))
        else $error("state moved without a cmd transfer");

endmodule

`default_nettype wire
